/* rtl/core/ror_pkg.sv */
// shared types and constants of the reliable ordered receiver
package ror_pkg;

  localparam int SEQ_W = 16;
  localparam int MASK_W = 32;
  localparam int ST_W = 3;
  localparam int MAX_DRAIN = 16;
  // ack window depth, indexed by the low sequence bits
  localparam int ACK_WINDOW = 32;

  localparam logic [ST_W-1:0] ST_REJECTED  = 3'd0;
  localparam logic [ST_W-1:0] ST_DUPLICATE = 3'd1;
  localparam logic [ST_W-1:0] ST_DELIVERED = 3'd2;
  localparam logic [ST_W-1:0] ST_BUFFERED  = 3'd3;
  localparam logic [ST_W-1:0] ST_FULL      = 3'd4;
  localparam logic [ST_W-1:0] ST_ACK       = 3'd5;

  localparam logic OP_RECV = 1'b0;
  localparam logic OP_ACK  = 1'b1;

  typedef logic [SEQ_W-1:0] seq_t;

  // controller to datapath
  typedef struct packed {
    logic load_in;     // capture the input request
    logic do_recv;     // apply the receive decision (record, buffer, deliver)
    logic do_ack;      // load ack header and clear pending flag
    logic mask_clr;    // start a mask build
    logic mask_step;   // one mask bit
    logic drain_step;  // one drain lookup/delivery
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic is_ack;
    logic drain_hit;
    logic mask_done;
  } dp_sts_t;

endpackage

/* rtl/core/ror_if.sv */
// valid/ready channel interfaces
interface ror_in_if;
  logic                 valid;
  logic                 ready;
  logic                 opcode;
  logic [15:0]          seq_num;
  logic                 is_reliable;
  logic                 is_ordered;
  modport source (output valid, opcode, seq_num, is_reliable, is_ordered, input ready);
  modport sink   (input valid, opcode, seq_num, is_reliable, is_ordered, output ready);
endinterface

interface ror_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  status;
  logic [15:0] delivered_seq;
  logic [31:0] ack_mask;
  logic [15:0] last_acked_out;
  logic        acks_pending;
  logic        last;
  modport source (output valid, status, delivered_seq, ack_mask, last_acked_out,
                  acks_pending, last, input ready);
  modport sink   (input valid, status, delivered_seq, ack_mask, last_acked_out,
                  acks_pending, last, output ready);
endinterface

/* rtl/core/reliable_ordered_receiver_core.sv */
// top level of the reliable ordered receiver
//
//  channel | dir | handshake          | payload
//  in_     | in  | in.valid/in.ready  | opcode, seq_num, is_reliable, is_ordered
//  out_    | out | out.valid/out.ready| status, delivered_seq, ack_mask,
//          |     |                    | last_acked_out, acks_pending, last
//
// a receive request is accepted, decoded and then shown as its first result;
// each drained successor is found by a compare over every reorder-store entry
// an ack request builds the mask one window bit per cycle before showing it
// rst_n is synchronous; the window and reorder valid bits clear at once
// one request at a time; results hold steady while out.ready is low
module reliable_ordered_receiver_core #(
  parameter int REORDER_DEPTH = 16
) (
  input logic      clk,
  input logic      rst_n,
  ror_in_if.sink   in,
  ror_out_if.source out
);
  import ror_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;
  logic [2:0] res_status;

  // datapath holds all sequence state and the result register
  ror_datapath #(
    .REORDER_DEPTH(REORDER_DEPTH)
  ) u_dp (
    .clk(clk),
    .rst_n(rst_n),
    .cmd(cmd),
    .sts(sts),
    .in_opcode(in.opcode),
    .in_seq_num(in.seq_num),
    .in_is_reliable(in.is_reliable),
    .in_is_ordered(in.is_ordered),
    .res_status(res_status),
    .res_seq(out.delivered_seq),
    .res_mask(out.ack_mask),
    .res_lack(out.last_acked_out),
    .res_pend(out.acks_pending)
  );

  assign out.status = res_status;

  // sequencing of decode, mask build and drain
  ror_ctrl u_ctrl (
    .clk(clk),
    .rst_n(rst_n),
    .in_valid(in.valid),
    .in_ready(in.ready),
    .out_valid(out.valid),
    .out_ready(out.ready),
    .out_last(out.last),
    .cmd(cmd),
    .sts(sts),
    .res_status(res_status)
  );
endmodule

/* rtl/core/ror_datapath.sv */
// receiver datapath: window, reorder store, mask builder and result register
module ror_datapath #(
  parameter int REORDER_DEPTH = 16
) (
  input  logic              clk,
  input  logic              rst_n,
  input  ror_pkg::dp_cmd_t  cmd,
  output ror_pkg::dp_sts_t  sts,
  input  logic              in_opcode,
  input  logic [15:0]       in_seq_num,
  input  logic              in_is_reliable,
  input  logic              in_is_ordered,
  output logic [2:0]        res_status,
  output logic [15:0]       res_seq,
  output logic [31:0]       res_mask,
  output logic [15:0]       res_lack,
  output logic              res_pend
);
  import ror_pkg::*;

  localparam int WI_W = $clog2(ACK_WINDOW);
  localparam int RD_W = (REORDER_DEPTH > 1) ? $clog2(REORDER_DEPTH) : 1;

  seq_t                    win_seq_r [ACK_WINDOW];
  logic [ACK_WINDOW-1:0]   win_ack_r;
  seq_t                    next_exp_r;
  seq_t                    last_ack_r;
  logic                    pend_r;
  logic [REORDER_DEPTH-1:0] rv_r;
  seq_t                    rs_r [REORDER_DEPTH];

  logic                    op_r, rel_r, ord_r;
  seq_t                    seq_r;
  logic [5:0]              mbit_r;
  seq_t                    mseq_r;

  logic [WI_W-1:0] w_idx, m_idx;
  logic            dup;
  logic [RD_W-1:0] free_idx, hit_idx;
  logic            free_ok, hit_ok;

  assign w_idx = seq_r[WI_W-1:0];
  assign m_idx = mseq_r[WI_W-1:0];
  assign dup   = win_ack_r[w_idx] && (win_seq_r[w_idx] == seq_r);

  always_comb begin
    free_ok = 1'b0;
    free_idx = '0;
    hit_ok = 1'b0;
    hit_idx = '0;
    for (int i = REORDER_DEPTH - 1; i >= 0; i--) begin
      if (!rv_r[i]) begin
        free_ok = 1'b1;
        free_idx = RD_W'(i);
      end
      if (rv_r[i] && rs_r[i] == next_exp_r) begin
        hit_ok = 1'b1;
        hit_idx = RD_W'(i);
      end
    end
  end

  assign sts.is_ack    = op_r;
  assign sts.drain_hit = hit_ok;
  assign sts.mask_done = (mbit_r == 6'd32);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      win_ack_r  <= '0;
      next_exp_r <= 16'd1;
      last_ack_r <= '0;
      pend_r     <= 1'b0;
      rv_r       <= '0;
      mbit_r     <= '0;
      for (int i = 0; i < ACK_WINDOW; i++) win_seq_r[i] <= '0;
    end else begin
      if (cmd.load_in) begin
        op_r  <= in_opcode;
        seq_r <= in_seq_num;
        rel_r <= in_is_reliable;
        ord_r <= in_is_ordered;
      end
      if (cmd.do_recv) begin
        res_seq  <= '0;
        res_mask <= '0;
        res_lack <= '0;
        res_pend <= 1'b0;
        if (!rel_r || !ord_r) begin
          res_status <= ST_REJECTED;
        end else if (dup) begin
          res_status <= ST_DUPLICATE;
        end else if (seq_r != next_exp_r) begin
          if (!free_ok) begin
            res_status <= ST_FULL;
          end else begin
            res_status <= ST_BUFFERED;
            win_seq_r[w_idx] <= seq_r;
            win_ack_r[w_idx] <= 1'b1;
            last_ack_r <= seq_r;
            pend_r <= 1'b1;
            rv_r[free_idx] <= 1'b1;
            rs_r[free_idx] <= seq_r;
          end
        end else begin
          res_status <= ST_DELIVERED;
          res_seq <= seq_r;
          win_seq_r[w_idx] <= seq_r;
          win_ack_r[w_idx] <= 1'b1;
          last_ack_r <= seq_r;
          pend_r <= 1'b1;
          next_exp_r <= next_exp_r + 16'd1;
        end
      end
      if (cmd.drain_step) begin
        rv_r[hit_idx] <= 1'b0;
        res_status <= ST_DELIVERED;
        res_seq <= next_exp_r;
        next_exp_r <= next_exp_r + 16'd1;
      end
      if (cmd.mask_clr) begin
        mbit_r <= '0;
        mseq_r <= last_ack_r - 16'd1;
        res_mask <= '0;
      end
      if (cmd.mask_step) begin
        res_mask[mbit_r[4:0]] <= win_ack_r[m_idx] && (win_seq_r[m_idx] == mseq_r);
        mbit_r <= mbit_r + 6'd1;
        mseq_r <= mseq_r - 16'd1;
      end
      if (cmd.do_ack) begin
        res_status <= ST_ACK;
        res_seq <= '0;
        res_lack <= last_ack_r;
        res_pend <= pend_r;
        pend_r <= 1'b0;
      end
    end
  end
endmodule

/* rtl/core/ror_ctrl.sv */
// receiver controller state machine
module ror_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output logic              out_valid,
  input  logic              out_ready,
  output logic              out_last,
  output ror_pkg::dp_cmd_t  cmd,
  input  ror_pkg::dp_sts_t  sts,
  input  logic [2:0]        res_status
);
  import ror_pkg::*;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_DEC  = 3'd1;
  localparam logic [2:0] S_MASK = 3'd2;
  localparam logic [2:0] S_OUT  = 3'd3;
  localparam logic [2:0] S_ACKO = 3'd4;

  logic [2:0] state_r, state_nxt;
  logic [4:0] drained_r, drained_nxt;
  logic       more;

  // another drain result follows the one on show
  assign more = (res_status == ST_DELIVERED) && sts.drain_hit &&
                (drained_r != 5'(MAX_DRAIN));

  always_comb begin
    state_nxt = state_r;
    drained_nxt = drained_r;
    cmd = '0;
    in_ready = 1'b0;
    out_valid = 1'b0;
    out_last = 1'b0;
    case (state_r)
      S_IDLE: begin
        in_ready = 1'b1;
        if (in_valid) begin
          cmd.load_in = 1'b1;
          state_nxt = S_DEC;
        end
      end
      S_DEC: begin
        drained_nxt = '0;
        if (sts.is_ack) begin
          cmd.mask_clr = 1'b1;
          state_nxt = S_MASK;
        end else begin
          cmd.do_recv = 1'b1;
          state_nxt = S_OUT;
        end
      end
      S_MASK: begin
        if (sts.mask_done) begin
          cmd.do_ack = 1'b1;
          state_nxt = S_ACKO;
        end else begin
          cmd.mask_step = 1'b1;
        end
      end
      S_ACKO: begin
        out_valid = 1'b1;
        out_last = 1'b1;
        if (out_ready) state_nxt = S_IDLE;
      end
      S_OUT: begin
        out_valid = 1'b1;
        out_last = !more;
        if (out_ready) begin
          if (more) begin
            cmd.drain_step = 1'b1;
            drained_nxt = drained_r + 5'd1;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      drained_r <= '0;
    end else begin
      state_r <= state_nxt;
      drained_r <= drained_nxt;
    end
  end
endmodule
